>>> rtl/core/lst_pkg.sv
// ----------------------------------------------------------------------------
// lst_pkg
// Shared types and constants of the LCD scanline timing block: mode codes,
// controller states, register indexes and the controller/datapath signals.
// ----------------------------------------------------------------------------
package lst_pkg;

  // Timing constants of one frame.
  localparam logic [6:0] CHUNK_DOTS    = 7'd80;
  localparam logic [9:0] LINE_DOTS     = 10'd456;
  localparam logic [7:0] LAST_LINE     = 8'd153;
  localparam logic [7:0] VISIBLE_LINES = 8'd144;
  localparam logic [8:0] OAM_END_DOT   = 9'd80;
  localparam logic [8:0] XFER_END_DOT  = 9'd252;

  // Packed result width: 23 field bits padded to three bytes.
  localparam int unsigned RESULT_W = 24;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_DISPLAY_ENABLE    = 3'd0;
  localparam logic [2:0] REG_HBLANK_IRQ_ENABLE = 3'd1;
  localparam logic [2:0] REG_VBLANK_IRQ_ENABLE = 3'd2;
  localparam logic [2:0] REG_OAM_IRQ_ENABLE    = 3'd3;
  localparam logic [2:0] REG_MATCH_IRQ_ENABLE  = 3'd4;
  localparam logic [2:0] REG_COMPARE_LINE      = 3'd5;
  localparam logic [2:0] REG_WINDOW_ENABLE     = 3'd6;
  localparam logic [2:0] REG_WINDOW_TOP_LINE   = 3'd7;

  // Display modes as reported on the result.
  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_WRITE = 2'd2
  } ctrl_state_t;

  // Configuration register contents.
  typedef struct packed {
    logic       display_enable;
    logic       hblank_irq_enable;
    logic       vblank_irq_enable;
    logic       oam_irq_enable;
    logic       match_irq_enable;
    logic [7:0] compare_line;
    logic       window_enable;
    logic [7:0] window_top_line;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // load a new tick and clear the per-tick flags
    logic step;      // process one chunk of up to 80 dots
    logic load_out;  // copy the tick result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_work;    // incoming tick advances the counters
    logic last_chunk;  // the chunk in progress uses up the tick
  } dp_status_t;

endpackage

>>> rtl/core/lst_ctrl.sv
// ----------------------------------------------------------------------------
// lst_ctrl
// Controller of the scanline timing block: accepts ticks, sequences the
// chunk steps of the datapath and hands results to the output register.
// ----------------------------------------------------------------------------
module lst_ctrl
  import lst_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  output logic       m_tvalid,
  input  logic       m_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;
  logic        m_tvalid_next;
  logic        out_free;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // The output register can take a result when empty or being drained.
  assign out_free = !m_tvalid || m_tready;

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    s_tready      = 1'b0;
    m_tvalid_next = m_tvalid && !m_tready;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.start  = 1'b1;
          state_next = status.has_work ? ST_RUN : ST_WRITE;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        if (status.last_chunk) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          m_tvalid_next = 1'b1;
          s_tready      = 1'b1;
          if (s_tvalid) begin
            cmd.start  = 1'b1;
            state_next = status.has_work ? ST_RUN : ST_WRITE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/lst_dpath.sv
// ----------------------------------------------------------------------------
// lst_dpath
// Datapath of the scanline timing block: dot and line counters, the mode
// register, window arming, per-tick request flags and the result register.
// ----------------------------------------------------------------------------
module lst_dpath
  import lst_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic [7:0]          dots,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  output logic [RESULT_W-1:0] result
);

  // Counter state.
  logic [7:0] left;
  logic [8:0] dot_count;
  logic [7:0] line_count;
  mode_t      current_mode;
  logic       window_armed;

  // Per-tick flags.
  logic       tick_vblank;
  logic       tick_status;
  logic       tick_strobe;
  logic [7:0] tick_rline;
  logic       tick_wstart;

  // One-chunk step.
  logic [6:0] chunk;
  logic [9:0] dot_sum;
  logic       wrap;
  logic [8:0] dot_step;
  logic [7:0] line_step;
  logic       visible;
  mode_t      target;
  logic       enter_vblank;
  logic       enter_visible;
  logic       line_match;
  logic       win_start;
  logic       status_hit;
  logic       strobe_hit;

  assign status.has_work   = cfg.display_enable && (dots != 8'd0);
  assign status.last_chunk = (left <= {1'b0, CHUNK_DOTS});

  // Advance by one chunk and work out which mode entry it causes.
  always_comb begin
    chunk     = (left >= {1'b0, CHUNK_DOTS}) ? CHUNK_DOTS : left[6:0];
    dot_sum   = {1'b0, dot_count} + {3'b000, chunk};
    wrap      = (dot_sum >= LINE_DOTS);
    dot_step  = wrap ? 9'(dot_sum - LINE_DOTS) : dot_sum[8:0];
    if (!wrap) begin
      line_step = line_count;
    end else if (line_count == LAST_LINE) begin
      line_step = 8'd0;
    end else begin
      line_step = line_count + 8'd1;
    end
    visible = (line_step < VISIBLE_LINES);

    if (dot_step <= OAM_END_DOT) begin
      target = MODE_OAM;
    end else if (dot_step <= XFER_END_DOT) begin
      target = MODE_XFER;
    end else begin
      target = MODE_HBLANK;
    end

    enter_vblank  = wrap && !visible && (current_mode != MODE_VBLANK);
    enter_visible = visible && (current_mode != target);
    line_match    = wrap && cfg.match_irq_enable && (line_step == cfg.compare_line);
    win_start     = enter_visible && (target == MODE_XFER) && cfg.window_enable &&
                    !window_armed && (line_step == cfg.window_top_line);
    strobe_hit    = enter_visible && (target == MODE_HBLANK);
    status_hit    = line_match ||
                    (enter_vblank && cfg.vblank_irq_enable) ||
                    (strobe_hit && cfg.hblank_irq_enable) ||
                    (enter_visible && (target == MODE_OAM) && cfg.oam_irq_enable);
  end

  // Counters, mode and per-tick flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_count    <= '0;
      line_count   <= '0;
      current_mode <= MODE_HBLANK;
      window_armed <= 1'b0;
      tick_vblank  <= 1'b0;
      tick_status  <= 1'b0;
      tick_strobe  <= 1'b0;
      tick_rline   <= '0;
      tick_wstart  <= 1'b0;
    end else if (cmd.start) begin
      tick_vblank <= 1'b0;
      tick_status <= 1'b0;
      tick_strobe <= 1'b0;
      tick_rline  <= '0;
      tick_wstart <= 1'b0;
    end else if (cmd.step) begin
      dot_count  <= dot_step;
      line_count <= line_step;
      if (enter_vblank) begin
        current_mode <= MODE_VBLANK;
        window_armed <= 1'b0;
      end else if (enter_visible) begin
        current_mode <= target;
        if (win_start) begin
          window_armed <= 1'b1;
        end
      end
      tick_vblank <= tick_vblank || enter_vblank;
      tick_status <= tick_status || status_hit;
      tick_wstart <= tick_wstart || win_start;
      if (strobe_hit) begin
        tick_strobe <= 1'b1;
        tick_rline  <= line_step;
      end
    end
  end

  // Remaining dots of the tick.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      left <= dots;
    end else if (cmd.step) begin
      left <= left - {1'b0, chunk};
    end
  end

  // Result register, packed from the lowest bit up.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result <= {1'b0, window_armed, tick_wstart, tick_rline, tick_strobe,
                 tick_status, tick_vblank, current_mode, line_count};
    end
  end

  // The dot counter always wraps before a full line.
  assert property (@(posedge clk) disable iff (rst) dot_count < LINE_DOTS[8:0])
    else $error("dot counter reached the line length");

  // Lines in vertical blank are only reached through a vertical blank entry.
  assert property (@(posedge clk) disable iff (rst)
    (line_count >= VISIBLE_LINES) |-> (current_mode == MODE_VBLANK))
    else $error("line in vertical blank while mode is not vertical blank");

  // The window never stays armed through vertical blank.
  assert property (@(posedge clk) disable iff (rst)
    (current_mode == MODE_VBLANK) |-> !window_armed)
    else $error("window armed during vertical blank");

  // A render line is only reported together with its strobe.
  assert property (@(posedge clk) disable iff (rst)
    !tick_strobe |-> (tick_rline == 8'd0))
    else $error("render line set without an hblank entry");

endmodule

>>> rtl/core/lcd_scanline_timing.sv
// Sequence: an accepted tick is stepped through the datapath in chunks of up to
//   80 dots (none when the display is off or dots is 0), and its result is loaded
//   into the output register once that register is empty or being drained.
// Throughput: the datapath steps one 80-dot chunk per cycle, at most four chunks
//   per tick; the next tick is taken as the previous result is loaded.
// Reset: synchronous, clears the counters, mode (horizontal blank), window
//   arming and all configuration registers.
// ----------------------------------------------------------------------------
// lcd_scanline_timing
// Scanline and mode sequencer of a tile-based LCD controller with an APB
// configuration port and stream channels for ticks and results.
// ----------------------------------------------------------------------------
module lcd_scanline_timing
  import lst_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // Tick requests.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,  // [7:0] dots
  // Result requests.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RESULT_W-1:0] m_tdata   // [7:0] line, [9:8] mode, [10] vblank_request,
                                        // [11] status_request, [12] render_strobe,
                                        // [20:13] render_line, [21] window_start,
                                        // [22] window_active, [23] zero
);

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_write;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_index)
        REG_DISPLAY_ENABLE:    cfg.display_enable    <= pwdata[0];
        REG_HBLANK_IRQ_ENABLE: cfg.hblank_irq_enable <= pwdata[0];
        REG_VBLANK_IRQ_ENABLE: cfg.vblank_irq_enable <= pwdata[0];
        REG_OAM_IRQ_ENABLE:    cfg.oam_irq_enable    <= pwdata[0];
        REG_MATCH_IRQ_ENABLE:  cfg.match_irq_enable  <= pwdata[0];
        REG_COMPARE_LINE:      cfg.compare_line      <= pwdata[7:0];
        REG_WINDOW_ENABLE:     cfg.window_enable     <= pwdata[0];
        REG_WINDOW_TOP_LINE:   cfg.window_top_line   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Register read back.
  always_comb begin
    prdata = '0;
    case (reg_index)
      REG_DISPLAY_ENABLE:    prdata[0]   = cfg.display_enable;
      REG_HBLANK_IRQ_ENABLE: prdata[0]   = cfg.hblank_irq_enable;
      REG_VBLANK_IRQ_ENABLE: prdata[0]   = cfg.vblank_irq_enable;
      REG_OAM_IRQ_ENABLE:    prdata[0]   = cfg.oam_irq_enable;
      REG_MATCH_IRQ_ENABLE:  prdata[0]   = cfg.match_irq_enable;
      REG_COMPARE_LINE:      prdata[7:0] = cfg.compare_line;
      REG_WINDOW_ENABLE:     prdata[0]   = cfg.window_enable;
      REG_WINDOW_TOP_LINE:   prdata[7:0] = cfg.window_top_line;
      default:               prdata      = '0;
    endcase
  end

  // Controller.
  lst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath.
  lst_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .dots   (s_tdata),
    .cmd    (cmd),
    .status (status),
    .result (m_tdata)
  );

endmodule
